/* rtl/stbeq_pkg.sv */
// Shared types and constants for the stereo three-band biquad equalizer.
// Used by stbeq_regs, stbeq_mul and stereo_three_band_biquad_eq.
// Has no dependencies of its own.
package stbeq_pkg;

    // Word and field widths.
    localparam int SAMPLE_W = 16;              // audio samples
    localparam int FRAC     = 16;              // fraction bits of signals and coefficients
    localparam int SIG_W    = 40;              // filter signal and history width
    localparam int HALF_W   = SIG_W / 2;       // signal half fed to the multiplier
    localparam int COEF_W   = 20;              // Q3.16 coefficient
    localparam int GAIN_W   = 20;              // unsigned Q4.16 gain
    localparam int ENABLE_W = 3;
    localparam int FF_W     = 3 * COEF_W;
    localparam int FB_W     = 2 * COEF_W;
    localparam int MOP_W    = COEF_W + 1;      // multiplier operand (signed)
    localparam int MPROD_W  = 2 * MOP_W;       // partial product
    localparam int PROD_W   = MOP_W + SIG_W;   // full coefficient by signal product
    localparam int TERM_W   = PROD_W - FRAC;   // product back at 16 fraction bits
    localparam int ACC_W    = 48;              // room for a three-term sum
    localparam int GAIN_SH  = 32;              // fraction bits of the output product
    localparam int Q_W      = PROD_W - GAIN_SH + 1;

    // Configuration port.
    localparam int DATA_W   = 64;
    localparam int ADDR_W   = 6;
    localparam int REG_BANDS = 3;              // coefficient sets in the register map
    localparam int BIDX_W   = $clog2(REG_BANDS);
    localparam int NUM_BANDS = 3;              // default number of processed bands

    localparam logic [GAIN_W-1:0] GAIN_RESET = 20'h10000;
    localparam logic [FF_W-1:0]   FF_RESET   = 60'h100_0000_0000_0000;
    localparam logic [FB_W-1:0]   FB_RESET   = '0;

    typedef enum logic [2:0] {
        REG_BAND_ENABLE,
        REG_MASTER_GAIN,
        REG_BASS_FF,
        REG_BASS_FB,
        REG_MID_FF,
        REG_MID_FB,
        REG_TREBLE_FF,
        REG_TREBLE_FB
    } t_reg_idx;

    typedef struct packed {
        logic [ENABLE_W-1:0]            enable;
        logic [GAIN_W-1:0]              gain;
        logic [REG_BANDS-1:0][FF_W-1:0] ff;
        logic [REG_BANDS-1:0][FB_W-1:0] fb;
    } t_cfg;

endpackage

/* rtl/stbeq_regs.sv */
// Configuration register file of the equalizer, written and read over APB.
// Depends on stbeq_pkg for widths, register indexes and the t_cfg struct.
module stbeq_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stbeq_pkg::ADDR_W-1:0]  paddr,
    input  logic [stbeq_pkg::DATA_W-1:0]  pwdata,
    output logic [stbeq_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output stbeq_pkg::t_cfg               o_cfg
);
    import stbeq_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable <= '0;
            r_cfg.gain   <= GAIN_RESET;
            for (int b = 0; b < REG_BANDS; b++) begin
                r_cfg.ff[b] <= FF_RESET;
                r_cfg.fb[b] <= FB_RESET;
            end
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BAND_ENABLE: r_cfg.enable <= pwdata[ENABLE_W-1:0];
                REG_MASTER_GAIN: r_cfg.gain   <= pwdata[GAIN_W-1:0];
                REG_BASS_FF:     r_cfg.ff[0]  <= pwdata[FF_W-1:0];
                REG_BASS_FB:     r_cfg.fb[0]  <= pwdata[FB_W-1:0];
                REG_MID_FF:      r_cfg.ff[1]  <= pwdata[FF_W-1:0];
                REG_MID_FB:      r_cfg.fb[1]  <= pwdata[FB_W-1:0];
                REG_TREBLE_FF:   r_cfg.ff[2]  <= pwdata[FF_W-1:0];
                REG_TREBLE_FB:   r_cfg.fb[2]  <= pwdata[FB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BAND_ENABLE: prdata = DATA_W'(r_cfg.enable);
            REG_MASTER_GAIN: prdata = DATA_W'(r_cfg.gain);
            REG_BASS_FF:     prdata = DATA_W'(r_cfg.ff[0]);
            REG_BASS_FB:     prdata = DATA_W'(r_cfg.fb[0]);
            REG_MID_FF:      prdata = DATA_W'(r_cfg.ff[1]);
            REG_MID_FB:      prdata = DATA_W'(r_cfg.fb[1]);
            REG_TREBLE_FF:   prdata = DATA_W'(r_cfg.ff[2]);
            REG_TREBLE_FB:   prdata = DATA_W'(r_cfg.fb[2]);
            default:         prdata = '0;
        endcase
    end

endmodule

/* rtl/stbeq_mul.sv */
// Shared multiplier of the equalizer: a 21 by 40 bit signed product formed
// from two 21 by 21 bit partial products. Uses stbeq_pkg.
module stbeq_mul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [stbeq_pkg::MOP_W-1:0]   i_coef,
    input  logic signed [stbeq_pkg::SIG_W-1:0]   i_sig,
    output logic                                 o_done,
    output logic signed [stbeq_pkg::PROD_W-1:0]  o_prod
);
    import stbeq_pkg::*;

    typedef enum logic [1:0] {MP_IDLE, MP_LO, MP_SUM} t_phase;

    t_phase                    r_phase;
    logic                      r_done;
    logic signed [MOP_W-1:0]   r_c;
    logic [HALF_W-1:0]         r_sig_lo;
    logic signed [MPROD_W-1:0] r_hi;
    logic signed [MPROD_W-1:0] r_lo;
    logic signed [PROD_W-1:0]  r_prod;

    logic signed [MOP_W-1:0]   mul_a;
    logic signed [MOP_W-1:0]   mul_b;
    logic signed [MPROD_W-1:0] mul_p;

    // The upper half goes in signed on the start cycle, the lower half
    // unsigned on the next one, both against the same coefficient.
    always_comb begin
        mul_a = i_start ? i_coef : r_c;
        mul_b = i_start ? $signed({i_sig[SIG_W-1], i_sig[SIG_W-1:HALF_W]})
                        : $signed({1'b0, r_sig_lo});
        mul_p = mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= MP_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_phase == MP_SUM);
            unique case (r_phase)
                MP_IDLE: begin
                    if (i_start) begin
                        r_c      <= i_coef;
                        r_sig_lo <= i_sig[HALF_W-1:0];
                        r_hi     <= mul_p;
                        r_phase  <= MP_LO;
                    end
                end
                MP_LO: begin
                    r_lo    <= mul_p;
                    r_phase <= MP_SUM;
                end
                MP_SUM: begin
                    r_prod  <= (PROD_W'(r_hi) <<< HALF_W) + PROD_W'(r_lo);
                    r_phase <= MP_IDLE;
                end
                default: r_phase <= MP_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

/* rtl/stereo_three_band_biquad_eq.sv */
// Stereo three-band biquad equalizer. Each product uses the one shared multiplier,
// and a band needs five products in sequence.
// Reset (synchronous, active low) zeroes histories and restores register defaults.
module stereo_three_band_biquad_eq #(
    parameter int BANDS = stbeq_pkg::NUM_BANDS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Input word channel.
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_cmd,
    input  logic signed [stbeq_pkg::SAMPLE_W-1:0]  i_left_in,
    input  logic signed [stbeq_pkg::SAMPLE_W-1:0]  i_right_in,
    input  logic                                   i_block_end_in,
    // Output word channel.
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [stbeq_pkg::SAMPLE_W-1:0]  o_left_out,
    output logic signed [stbeq_pkg::SAMPLE_W-1:0]  o_right_out,
    output logic                                   o_block_end_out,
    // APB configuration port.
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [stbeq_pkg::ADDR_W-1:0]           paddr,
    input  logic [stbeq_pkg::DATA_W-1:0]           pwdata,
    output logic [stbeq_pkg::DATA_W-1:0]           prdata,
    output logic                                   pready
);
    import stbeq_pkg::*;

    // History layout: channel, then band, then z1/z2.
    localparam int HIST_N  = 4 * BANDS;
    localparam int HIDX_W  = $clog2(HIST_N);
    localparam int BCNT_W  = $clog2(BANDS + 1);

    // The sequencer walks bands of one channel, then the output gain, then
    // repeats for the other channel. Within a band five products run in order.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BAND,
        ST_ISSUE,
        ST_WAIT,
        ST_GAIN_ISSUE,
        ST_GAIN_WAIT,
        ST_FINISH
    } t_state;

    typedef enum logic [2:0] {
        STEP_Y,     // y  = sat(b0*x + z1)
        STEP_Z1A,   // acc = b1*x + z2
        STEP_Z1B,   // z1 = sat(acc - a1*y)
        STEP_Z2A,   // acc = b2*x
        STEP_Z2B    // z2 = sat(acc - a2*y)
    } t_step;

    t_cfg cfg;

    t_state                     r_state;
    t_step                      r_step;
    logic                       r_chan;
    logic [BCNT_W-1:0]          r_band;
    logic signed [SIG_W-1:0]    r_x;
    logic signed [SIG_W-1:0]    r_y;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SIG_W-1:0]    r_hist [HIST_N];
    logic signed [SAMPLE_W-1:0] r_right_smp;
    logic                       r_bend;
    logic signed [SAMPLE_W-1:0] r_left_q;
    logic signed [SAMPLE_W-1:0] r_right_q;
    logic                       r_ovalid;
    logic signed [SAMPLE_W-1:0] r_lout;
    logic signed [SAMPLE_W-1:0] r_rout;
    logic                       r_bout;

    logic                       in_acc;
    logic                       out_free;
    logic [BIDX_W-1:0]          bidx;
    logic [FF_W-1:0]            ff;
    logic [FB_W-1:0]            fb;
    logic [COEF_W-1:0]          coef_sel;
    logic                       hist_k;
    logic [HIDX_W-1:0]          hidx;
    logic signed [SIG_W-1:0]    hist_rd;
    logic                       mul_start;
    logic signed [MOP_W-1:0]    mul_coef;
    logic signed [SIG_W-1:0]    mul_sig;
    logic                       mul_done;
    logic signed [PROD_W-1:0]   mul_prod;
    logic signed [ACC_W-1:0]    term;
    logic signed [ACC_W-1:0]    sum_y;
    logic signed [ACC_W-1:0]    sum_z2;
    logic signed [ACC_W-1:0]    diff;
    logic signed [Q_W-1:0]      q_full;
    logic signed [SAMPLE_W-1:0] q_sat;

    // Saturate a wide sum to the 40-bit signal range.
    function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-SIG_W:0] top;
        top = v[ACC_W-1:SIG_W-1];
        if ((top == '0) || (top == '1)) begin
            return v[SIG_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(SIG_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SIG_W-1){1'b1}}};
        end
    endfunction

    stbeq_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    stbeq_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_coef  (mul_coef),
        .i_sig   (mul_sig),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // The block takes one word at a time; a finished result waiting in the
    // output register does not hold off the next input word.
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_ovalid || !i_out_stall;

    always_comb begin
        bidx = BIDX_W'(r_band);
        ff   = cfg.ff[bidx];
        fb   = cfg.fb[bidx];

        // Coefficient and signal operand for the current product.
        case (r_step)
            STEP_Y:   coef_sel = ff[3*COEF_W-1:2*COEF_W];
            STEP_Z1A: coef_sel = ff[2*COEF_W-1:COEF_W];
            STEP_Z1B: coef_sel = fb[2*COEF_W-1:COEF_W];
            STEP_Z2A: coef_sel = ff[COEF_W-1:0];
            STEP_Z2B: coef_sel = fb[COEF_W-1:0];
            default:  coef_sel = '0;
        endcase

        mul_start = (r_state == ST_ISSUE) || (r_state == ST_GAIN_ISSUE);
        if (r_state == ST_GAIN_ISSUE) begin
            mul_coef = $signed({1'b0, cfg.gain});
            mul_sig  = r_x;
        end else begin
            mul_coef = $signed({coef_sel[COEF_W-1], coef_sel});
            mul_sig  = ((r_step == STEP_Z1B) || (r_step == STEP_Z2B)) ? r_y : r_x;
        end

        // z1 is touched in the first and third steps, z2 in the second and last.
        hist_k  = (r_step == STEP_Z1A) || (r_step == STEP_Z2B);
        hidx    = HIDX_W'((32'(r_chan) * 2 * BANDS) + (32'(r_band) * 2) + 32'(hist_k));
        hist_rd = r_hist[hidx];

        // Products are floored back to 16 fraction bits before any sum.
        term   = ACC_W'(TERM_W'(mul_prod >>> FRAC));
        sum_y  = term + ACC_W'(hist_rd);
        sum_z2 = term + ACC_W'(hist_rd);
        diff   = r_acc - term;

        // Output gain: drop 32 fraction bits rounding toward zero, then clip.
        q_full = Q_W'(mul_prod >>> GAIN_SH)
                 + Q_W'({1'b0, mul_prod[PROD_W-1] && (|mul_prod[GAIN_SH-1:0])});
        if ((q_full[Q_W-1:SAMPLE_W-1] == '0) || (q_full[Q_W-1:SAMPLE_W-1] == '1)) begin
            q_sat = q_full[SAMPLE_W-1:0];
        end else if (q_full[Q_W-1]) begin
            q_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            q_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= STEP_Y;
            r_chan   <= 1'b0;
            r_band   <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < HIST_N; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            // The output register fills from the finishing state and empties
            // when the receiver takes the word.
            if ((r_state == ST_FINISH) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_cmd) begin
                            for (int i = 0; i < HIST_N; i++) begin
                                r_hist[i] <= '0;
                            end
                        end else begin
                            r_x         <= SIG_W'($signed({i_left_in, {FRAC{1'b0}}}));
                            r_right_smp <= i_right_in;
                            r_bend      <= i_block_end_in;
                            r_chan      <= 1'b0;
                            r_band      <= '0;
                            r_state     <= ST_BAND;
                        end
                    end
                end
                ST_BAND: begin
                    // Bypassed bands leave their history alone.
                    if (r_band == BCNT_W'(BANDS)) begin
                        r_state <= ST_GAIN_ISSUE;
                    end else if (cfg.enable[bidx]) begin
                        r_step  <= STEP_Y;
                        r_state <= ST_ISSUE;
                    end else begin
                        r_band <= r_band + BCNT_W'(1);
                    end
                end
                ST_ISSUE: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (mul_done) begin
                        r_state <= ST_ISSUE;
                        case (r_step)
                            STEP_Y: begin
                                r_y    <= sat_sig(sum_y);
                                r_step <= STEP_Z1A;
                            end
                            STEP_Z1A: begin
                                r_acc  <= sum_z2;
                                r_step <= STEP_Z1B;
                            end
                            STEP_Z1B: begin
                                r_hist[hidx] <= sat_sig(diff);
                                r_step       <= STEP_Z2A;
                            end
                            STEP_Z2A: begin
                                r_acc  <= term;
                                r_step <= STEP_Z2B;
                            end
                            STEP_Z2B: begin
                                r_hist[hidx] <= sat_sig(diff);
                                r_x          <= r_y;
                                r_band       <= r_band + BCNT_W'(1);
                                r_step       <= STEP_Y;
                                r_state      <= ST_BAND;
                            end
                            default: r_step <= STEP_Y;
                        endcase
                    end
                end
                ST_GAIN_ISSUE: begin
                    r_state <= ST_GAIN_WAIT;
                end
                ST_GAIN_WAIT: begin
                    if (mul_done) begin
                        if (!r_chan) begin
                            // Left done: start the right channel from band zero.
                            r_left_q <= q_sat;
                            r_chan   <= 1'b1;
                            r_band   <= '0;
                            r_x      <= SIG_W'($signed({r_right_smp, {FRAC{1'b0}}}));
                            r_state  <= ST_BAND;
                        end else begin
                            r_right_q <= q_sat;
                            r_state   <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH: begin
                    // Wait for the output register to free up before handing off.
                    if (out_free) begin
                        r_lout   <= r_left_q;
                        r_rout   <= r_right_q;
                        r_bout   <= r_bend;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_left_out      = r_lout;
    assign o_right_out     = r_rout;
    assign o_block_end_out = r_bout;

`ifndef SYNTHESIS
    // The multiplier only reports a product while the sequencer waits for one.
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> ((r_state == ST_WAIT) || (r_state == ST_GAIN_WAIT)))
        else $error("multiplier result arrived outside a wait state");

    // A new result is only ever loaded from the finishing state.
    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == ST_FINISH))
        else $error("output word loaded outside the finishing state");

    // The finishing state hands off once the output side is free.
    a_finish_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FINISH) && out_free) |=> (r_ovalid && (r_state == ST_IDLE)))
        else $error("finished word was not handed to the output register");

    // A clear command leaves the first and last history entries at zero.
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_cmd) |=> ((r_hist[0] == '0) && (r_hist[HIST_N-1] == '0)))
        else $error("history not cleared by clear command");

    // The band counter never runs past the configured band count.
    a_band_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_band <= BCNT_W'(BANDS)))
        else $error("band counter out of range");
`endif

endmodule

/* dv/stereo_three_band_biquad_eq_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for stereo_three_band_biquad_eq: directed and random stereo frames,
// bit-exact equalizer prediction, random back-pressure and APB register writes with readback.
// Depends on rtl/stbeq_pkg.sv and rtl/stereo_three_band_biquad_eq.sv.
module stereo_three_band_biquad_eq_test;
    import stbeq_pkg::*;

    // WORD_CYCLES bounds the slowest word, with every band enabled; settling for
    // SETTLE_CYCLES covers any work still in flight after the last result.
    localparam int    WORD_CYCLES    = 140;
    localparam int    SETTLE_CYCLES  = 2 * WORD_CYCLES;
    localparam int    RANDOM_PHASES  = 12;
    localparam int    PHASE_WORDS    = 100;
    localparam int    HOLDOFF_CYCLES = 900;
    localparam longint SIG_HI = 64'sd549755813887;
    localparam longint SIG_LO = -SIG_HI - 1;
    localparam t_reg_idx FF_REG[REG_BANDS] = '{REG_BASS_FF, REG_MID_FF, REG_TREBLE_FF};
    localparam t_reg_idx FB_REG[REG_BANDS] = '{REG_BASS_FB, REG_MID_FB, REG_TREBLE_FB};

    typedef struct {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       block_end;
    } t_frame;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic                       i_cmd;
    logic signed [SAMPLE_W-1:0] i_left_in;
    logic signed [SAMPLE_W-1:0] i_right_in;
    logic                       i_block_end_in;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic signed [SAMPLE_W-1:0] o_left_out;
    logic signed [SAMPLE_W-1:0] o_right_out;
    logic                       o_block_end_out;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [DATA_W-1:0]          pwdata;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;

    // Shadow copy of the register file and of both channels' filter histories.
    t_cfg   eq_cfg;
    longint eq_hist[2][2*REG_BANDS];

    // Frames predicted at input acceptance, oldest first.
    t_frame pending_frames[$];

    int mismatches;
    int frames_checked;
    int frames_sent;
    int clears_sent;
    int settings_applied;
    int holdoff_left;
    int burst_left;

    stereo_three_band_biquad_eq i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_left_in      (i_left_in),
        .i_right_in     (i_right_in),
        .i_block_end_in (i_block_end_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_left_out     (o_left_out),
        .o_right_out    (o_right_out),
        .o_block_end_out(o_block_end_out),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------
    // Equalizer predictor
    // ------------------------------------------------------------------

    function automatic longint sext(input logic [63:0] v, input int w);
        longint r;
        r = v;
        r = (r <<< (64 - w)) >>> (64 - w);
        return r;
    endfunction

    function automatic longint sat_sig(input longint v);
        if (v > SIG_HI) return SIG_HI;
        if (v < SIG_LO) return SIG_LO;
        return v;
    endfunction

    // Coefficient times signal, floored back to 16 fraction bits.
    function automatic longint coef_mul(input longint c, input longint s);
        return (c * s) >>> FRAC;
    endfunction

    // One channel through the enabled sections, then master gain and clamp.
    function automatic logic [SAMPLE_W-1:0] eq_channel(input int ch,
                                                     input logic signed [SAMPLE_W-1:0] smp);
        longint s, y, b0, b1, b2, a1, a2, g, p, q;
        s = smp;
        s = s * 65536;
        for (int b = 0; b < NUM_BANDS; b++) begin
            if (eq_cfg.enable[b]) begin
                b0 = sext(eq_cfg.ff[b][59:40], COEF_W);
                b1 = sext(eq_cfg.ff[b][39:20], COEF_W);
                b2 = sext(eq_cfg.ff[b][19:0], COEF_W);
                a1 = sext(eq_cfg.fb[b][39:20], COEF_W);
                a2 = sext(eq_cfg.fb[b][19:0], COEF_W);
                y = sat_sig(coef_mul(b0, s) + eq_hist[ch][2*b]);
                eq_hist[ch][2*b] = sat_sig(coef_mul(b1, s) - coef_mul(a1, y)
                                           + eq_hist[ch][2*b+1]);
                eq_hist[ch][2*b+1] = sat_sig(coef_mul(b2, s) - coef_mul(a2, y));
                s = y;
            end
        end
        g = eq_cfg.gain;
        p = s * g;
        // The gain product is truncated toward zero, not floored.
        if (p >= 0) q = p >>> GAIN_SH;
        else q = -((-p) >>> GAIN_SH);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[SAMPLE_W-1:0];
    endfunction

    function automatic void clear_histories();
        for (int c = 0; c < 2; c++)
            for (int k = 0; k < 2*REG_BANDS; k++)
                eq_hist[c][k] = 0;
    endfunction

    task automatic predict_word(input logic cmd, input logic signed [SAMPLE_W-1:0] l,
                                input logic signed [SAMPLE_W-1:0] r, input logic be);
        t_frame f;
        if (cmd) begin
            clear_histories();
            clears_sent++;
        end else begin
            f.left = eq_channel(0, l);
            f.right = eq_channel(1, r);
            f.block_end = be;
            pending_frames.push_back(f);
            frames_sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // Register access
    // ------------------------------------------------------------------

    function automatic int reg_width(input t_reg_idx idx);
        case (idx)
            REG_BAND_ENABLE: return ENABLE_W;
            REG_MASTER_GAIN: return GAIN_W;
            REG_BASS_FF, REG_MID_FF, REG_TREBLE_FF: return FF_W;
            default: return FB_W;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] shadow_value(input t_reg_idx idx);
        case (idx)
            REG_BAND_ENABLE: return eq_cfg.enable;
            REG_MASTER_GAIN: return eq_cfg.gain;
            REG_BASS_FF:     return eq_cfg.ff[0];
            REG_BASS_FB:     return eq_cfg.fb[0];
            REG_MID_FF:      return eq_cfg.ff[1];
            REG_MID_FB:      return eq_cfg.fb[1];
            REG_TREBLE_FF:   return eq_cfg.ff[2];
            default:         return eq_cfg.fb[2];
        endcase
    endfunction

    // One APB transfer: setup phase, access phase, done when pready is seen.
    task automatic apb_transfer(input t_reg_idx idx, input logic wr,
                                input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = ADDR_W'(idx) << 3;
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic check_reg(input t_reg_idx idx);
        apb_transfer(idx, 1'b0, '0);
        if (prdata !== shadow_value(idx)) begin
            $display("%0t: register %s read back %h, expected %h", $time, idx.name(),
                     prdata, shadow_value(idx));
            mismatches++;
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // Writes a register with junk above its width, which the block must drop.
    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] data;
        int w;
        w = reg_width(idx);
        data = {$urandom, $urandom};
        for (int k = 0; k < w; k++) data[k] = value[k];
        apb_transfer(idx, 1'b1, data);
        case (idx)
            REG_BAND_ENABLE: eq_cfg.enable = data[ENABLE_W-1:0];
            REG_MASTER_GAIN: eq_cfg.gain = data[GAIN_W-1:0];
            REG_BASS_FF:     eq_cfg.ff[0] = data[FF_W-1:0];
            REG_BASS_FB:     eq_cfg.fb[0] = data[FB_W-1:0];
            REG_MID_FF:      eq_cfg.ff[1] = data[FF_W-1:0];
            REG_MID_FB:      eq_cfg.fb[1] = data[FB_W-1:0];
            REG_TREBLE_FF:   eq_cfg.ff[2] = data[FF_W-1:0];
            default:         eq_cfg.fb[2] = data[FB_W-1:0];
        endcase
        check_reg(idx);
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    task automatic send_word(input logic cmd, input logic signed [SAMPLE_W-1:0] l,
                             input logic signed [SAMPLE_W-1:0] r, input logic be);
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_cmd = cmd;
        i_left_in = l;
        i_right_in = r;
        i_block_end_in = be;
        do @(posedge i_clk); while (o_in_stall);
        predict_word(cmd, l, r, be);
    endtask

    task automatic idle_input(input int cycles);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Holds the input off until every predicted frame is out and the block has
    // had time to finish a trailing clear. Register writes are only made after this.
    task automatic wait_for_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) return SAMPLE_W'($urandom);
        if (pick < 9) return SAMPLE_W'(int'($urandom_range(0, 1024)) - 512);
        return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    endfunction

    task automatic send_random_word();
        send_word($urandom_range(0, 99) < 4, random_sample(), random_sample(),
                  $urandom_range(0, 7) == 0);
    endtask

    // Bursts of random length, most after a random gap; the long gaps land on
    // every phase of the block's per-word schedule.
    task automatic send_stream(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                pick = $urandom_range(0, 9);
                if (pick >= 8) idle_input($urandom_range(20, 160));
                else if (pick >= 4) idle_input($urandom_range(1, 8));
            end
            burst_left--;
            send_random_word();
        end
    endtask

    // ------------------------------------------------------------------
    // Configuration settings
    // ------------------------------------------------------------------

    task automatic apply_setting(input logic [ENABLE_W-1:0] enable,
                                 input logic [GAIN_W-1:0] gain,
                                 input logic [FF_W-1:0] ff[REG_BANDS],
                                 input logic [FB_W-1:0] fb[REG_BANDS]);
        wait_for_idle();
        write_reg(REG_BAND_ENABLE, enable);
        write_reg(REG_MASTER_GAIN, gain);
        for (int b = 0; b < REG_BANDS; b++) begin
            write_reg(FF_REG[b], ff[b]);
            write_reg(FB_REG[b], fb[b]);
        end
        settings_applied++;
    endtask

    // Either a section inside the stability triangle with moderate zeros, or
    // raw random bits that will usually drive the histories into saturation.
    task automatic random_section(input logic stable, output logic [FF_W-1:0] ff,
                                  output logic [FB_W-1:0] fb);
        int a1, a2, lim, b0, b1, b2;
        if (stable) begin
            a2 = int'($urandom_range(0, 120000)) - 58982;
            lim = (65536 + a2) * 15 / 16;
            a1 = int'($urandom_range(0, 2 * lim)) - lim;
            b0 = int'($urandom_range(0, 262144)) - 131072;
            b1 = int'($urandom_range(0, 262144)) - 131072;
            b2 = int'($urandom_range(0, 262144)) - 131072;
            ff = {b0[COEF_W-1:0], b1[COEF_W-1:0], b2[COEF_W-1:0]};
            fb = {a1[COEF_W-1:0], a2[COEF_W-1:0]};
        end else begin
            ff = FF_W'({$urandom, $urandom});
            fb = FB_W'({$urandom, $urandom});
        end
    endtask

    task automatic random_setting(input int phase);
        logic [ENABLE_W-1:0] enable;
        logic [GAIN_W-1:0]   gain;
        logic [FF_W-1:0]     ff[REG_BANDS];
        logic [FB_W-1:0]     fb[REG_BANDS];
        logic                wild;
        wild = $urandom_range(0, 4) == 0;
        if (phase == 0) enable = '1;
        else if (phase == 1) enable = '0;
        else enable = ENABLE_W'($urandom);
        if ($urandom_range(0, 3) == 0) gain = GAIN_W'($urandom);
        else gain = GAIN_W'($urandom_range(16384, 131072));
        for (int b = 0; b < REG_BANDS; b++) random_section(!wild, ff[b], fb[b]);
        apply_setting(enable, gain, ff, fb);
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // The receiver switches between no stalls, light and heavy random stalls
    // and a fixed on/off pattern; a requested hold-off overrides all of them.
    always @(negedge i_clk) begin : out_stall_gen
        int mode, mode_left, pattern;
        if (holdoff_left > 0) begin
            i_out_stall = 1'b1;
            holdoff_left--;
        end else begin
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            pattern++;
            case (mode)
                0: i_out_stall = 1'b0;
                1: i_out_stall = $urandom_range(0, 9) < 3;
                2: i_out_stall = $urandom_range(0, 9) < 8;
                default: i_out_stall = pattern[3] & pattern[1];
            endcase
        end
    end

    always @(posedge i_clk) begin : frame_checker
        t_frame f;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_frames.size() == 0) begin
                $display("%0t: unexpected word left=%0d right=%0d block_end=%0b", $time,
                         o_left_out, o_right_out, o_block_end_out);
                mismatches++;
            end else begin
                f = pending_frames.pop_front();
                frames_checked++;
                if (o_left_out !== f.left) begin
                    $display("%0t: left_out expected %0d, got %0d", $time, f.left, o_left_out);
                    mismatches++;
                end
                if (o_right_out !== f.right) begin
                    $display("%0t: right_out expected %0d, got %0d", $time, f.right,
                             o_right_out);
                    mismatches++;
                end
                if (o_block_end_out !== f.block_end) begin
                    $display("%0t: block_end_out expected %0b, got %0b", $time, f.block_end,
                             o_block_end_out);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values read back, then bypass frames must come out unchanged.
    task automatic test_reset_state();
        for (int k = 0; k <= REG_TREBLE_FB; k++) check_reg(t_reg_idx'(k));
        send_word(1'b0, 16'sh0000, 16'sh0000, 1'b0);
        send_word(1'b0, 16'sh7FFF, 16'sh8000, 1'b1);
        send_word(1'b0, 16'sh8000, 16'sh7FFF, 1'b0);
        send_word(1'b0, -16'sd1, 16'sd1, 1'b1);
        send_word(1'b0, 16'sh5555, 16'shAAAA, 1'b0);
        // A clear ignores its samples and block end and yields no word.
        send_word(1'b1, 16'sh7FFF, 16'sh8000, 1'b1);
        send_word(1'b0, 16'shAAAA, 16'sh5555, 1'b1);
    endtask

    // Coefficients and gain at their limits push the sums toward saturation;
    // a clear in the middle must bring the recursion back to zero history.
    task automatic test_coefficient_extremes();
        logic [FF_W-1:0] ff[REG_BANDS];
        logic [FB_W-1:0] fb[REG_BANDS];
        for (int b = 0; b < REG_BANDS; b++) begin
            ff[b] = {20'h7FFFF, 20'h80000, 20'h7FFFF};
            fb[b] = {20'h80000, 20'h7FFFF};
        end
        apply_setting('1, '1, ff, fb);
        send_word(1'b0, 16'sh7FFF, 16'sh8000, 1'b0);
        send_word(1'b0, 16'sh8000, 16'sh7FFF, 1'b1);
        send_word(1'b0, 16'sd1, -16'sd1, 1'b0);
        send_word(1'b0, 16'sd0, 16'sd0, 1'b0);
        send_word(1'b1, 16'sd0, 16'sd0, 1'b0);
        send_word(1'b0, 16'sh7FFF, 16'sh7FFF, 1'b1);
        for (int b = 0; b < REG_BANDS; b++) begin
            ff[b] = {20'h80000, 20'h7FFFF, 20'h80000};
            fb[b] = {20'h7FFFF, 20'h80000};
        end
        apply_setting(3'b101, '0, ff, fb);
        send_word(1'b0, 16'sh7FFF, 16'sh8000, 1'b1);
        send_word(1'b0, 16'sh1234, -16'sh1234, 1'b0);
        send_word(1'b1, 16'sh8000, 16'sh8000, 1'b0);
        send_word(1'b0, 16'sh8000, 16'sh7FFF, 1'b0);
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_setting(ph);
            send_stream(PHASE_WORDS);
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering words back to back, so the block fills up and stalls its input.
    // Afterwards the sender pauses until the output has drained completely.
    task automatic test_output_holdoff();
        random_setting(0);
        @(negedge i_clk);
        holdoff_left = HOLDOFF_CYCLES;
        repeat (40) send_random_word();
        wait_for_idle();
        send_stream(190);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_cmd = 1'b0;
        i_left_in = '0;
        i_right_in = '0;
        i_block_end_in = 1'b0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        frames_checked = 0;
        frames_sent = 0;
        clears_sent = 0;
        settings_applied = 0;
        holdoff_left = 0;
        burst_left = 0;
        eq_cfg.enable = '0;
        eq_cfg.gain = GAIN_RESET;
        for (int b = 0; b < REG_BANDS; b++) begin
            eq_cfg.ff[b] = FF_RESET;
            eq_cfg.fb[b] = FB_RESET;
        end
        clear_histories();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_coefficient_extremes();
        test_random_settings();
        test_output_holdoff();

        wait_for_idle();
        $display("Checked %0d equalized frames and %0d history clears under %0d settings,",
                 frames_checked, clears_sent, settings_applied);
        $display("with random output stalls, input bursts and a %0d-cycle output hold-off.",
                 HOLDOFF_CYCLES);
        if (mismatches == 0 && pending_frames.size() == 0) begin
            $display("stereo_three_band_biquad_eq test passed");
        end else begin
            $display("stereo_three_band_biquad_eq test failed");
        end
        $finish;
    end

    // Generous ceiling: roughly ten times the slowest correct run.
    initial begin
        #36000000;
        $display("Timeout with %0d frames still outstanding", pending_frames.size());
        $display("stereo_three_band_biquad_eq test failed");
        $finish;
    end

endmodule

/* stereo_three_band_biquad_eq.f */
rtl/stbeq_pkg.sv
rtl/stbeq_regs.sv
rtl/stbeq_mul.sv
rtl/stereo_three_band_biquad_eq.sv
dv/stereo_three_band_biquad_eq_test.sv
